// File: src/sirt_pkg.sv
package sirt_pkg;

    // Field and register widths.
    localparam int NUMBER_W        = 32;
    localparam int CHAR_W          = 8;
    localparam int REG_W           = 64;
    localparam int LEN_W           = 5;
    localparam int CFG_INDEX_W     = 2;
    localparam int SYMBOL_COUNT    = 16;
    localparam int SYMBOL_IDX_W    = 4;

    // Divider: quotient bits resolved per cycle and phases per digit.
    localparam int DIV_BITS        = 8;
    localparam int DIV_PHASES      = NUMBER_W / DIV_BITS;
    localparam int PHASE_W         = $clog2(DIV_PHASES);
    localparam int REM_W           = 4;

    // Fixed characters.
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYMBOLS_LOW      = 2'd0,
        REG_SYMBOLS_HIGH     = 2'd1,
        REG_ALPHABET_LENGTH  = 2'd2
    } reg_index_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CHECK   = 7'b0000010,
        ST_SIGN    = 7'b0000100,
        ST_DIVIDE  = 7'b0001000,
        ST_READ    = 7'b0010000,
        ST_EMIT    = 7'b0100000,
        ST_NEWLINE = 7'b1000000
    } state_t;

    // Commands from the sequencer to the divider.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // Status from the divider, valid in the cycle of a step.
    typedef struct packed {
        logic             done;
        logic             quot_zero;
        logic [REM_W-1:0] rem;
    } div_sts_t;

endpackage

// File: src/sirt_if.sv
// Channel that carries one number to convert.
interface sirt_number_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sirt_pkg::NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

// Channel that carries one text character.
interface sirt_text_if;
    logic                         valid;
    logic                         ready;
    logic [sirt_pkg::CHAR_W-1:0]  character;
    logic                         last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

// File: src/sirt_divider.sv
module sirt_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sirt_pkg::div_ctl_t            ctl,
    input  logic [sirt_pkg::NUMBER_W-1:0] load_value,
    input  logic [sirt_pkg::LEN_W-1:0]    radix,
    output sirt_pkg::div_sts_t            sts
);

    localparam int NW = sirt_pkg::NUMBER_W;
    localparam int RW = sirt_pkg::REM_W;
    localparam int PW = sirt_pkg::PHASE_W;
    localparam int LW = sirt_pkg::LEN_W;

    logic [NW-1:0] mag_reg;
    logic [NW-1:0] mag_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;

    logic [NW-1:0] shift_mag;
    logic [RW-1:0] shift_rem;
    logic [LW-1:0] trial;

    // Restoring division, several quotient bits a cycle. The quotient bits
    // shift into the low end of the magnitude as the dividend leaves the top.
    always_comb
    begin
        shift_mag = mag_reg;
        shift_rem = (phase_reg == '0) ? '0 : rem_reg;
        trial     = '0;
        for (int k = 0; k < sirt_pkg::DIV_BITS; k++)
        begin
            trial     = {shift_rem, shift_mag[NW-1]};
            shift_mag = {shift_mag[NW-2:0], 1'b0};
            if (trial >= radix)
            begin
                trial        = trial - radix;
                shift_mag[0] = 1'b1;
            end
            shift_rem = trial[RW-1:0];
        end
    end

    // Next-state selection for the divider registers.
    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        if (ctl.load)
        begin
            mag_next   = load_value;
            rem_next   = '0;
            phase_next = '0;
        end
        else if (ctl.step)
        begin
            mag_next   = shift_mag;
            rem_next   = shift_rem;
            phase_next = PW'(phase_reg + 1'b1);
        end
    end

    assign sts.done      = ctl.step && (phase_reg == PW'(sirt_pkg::DIV_PHASES - 1));
    assign sts.quot_zero = (shift_mag == '0);
    assign sts.rem       = shift_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            rem_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            mag_reg   <= mag_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// File: src/signed_integer_to_radix_text.sv
// Sequence: the alphabet is checked one symbol at a time, then a minus sign is queued
// for a negative value, the divider produces the digits, and each digit is read back
// and emitted; output stalls hold the sign, emit and newline steps. An invalid
// alphabet drops the item during the check, and the next item can then be taken.
// Throughput: one item at a time; the next is taken once the newline is queued.
// Reset: rst_n is asynchronous, active low; it clears control and configuration.
module signed_integer_to_radix_text
#(
    parameter int MAX_SYMBOLS = 16,
    parameter int DIGIT_SLOTS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sirt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sirt_pkg::REG_W-1:0]       cfg_data,
    sirt_number_if.sink                      numbers,
    sirt_text_if.source                      text
);

    localparam int LW   = sirt_pkg::LEN_W;
    localparam int CW   = sirt_pkg::CHAR_W;
    localparam int NW   = sirt_pkg::NUMBER_W;
    localparam int SIW  = sirt_pkg::SYMBOL_IDX_W;
    localparam int CHKW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int AW   = $clog2(DIGIT_SLOTS);
    localparam int CNTW = AW + 1;

    // Configuration registers.
    logic [sirt_pkg::REG_W-1:0] symbols_low_reg;
    logic [sirt_pkg::REG_W-1:0] symbols_high_reg;
    logic [LW-1:0]              alphabet_length_reg;

    // Sequencer registers.
    sirt_pkg::state_t state_reg;
    sirt_pkg::state_t state_next;
    logic [CHKW-1:0]  chk_idx_reg;
    logic [CHKW-1:0]  chk_idx_next;
    logic [CNTW-1:0]  cnt_reg;
    logic [CNTW-1:0]  cnt_next;
    logic             neg_reg;
    logic             neg_next;

    // Output register.
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CW-1:0] out_char_reg;
    logic [CW-1:0] out_char_next;
    logic          out_last_reg;
    logic          out_last_next;

    // Digit store.
    logic [CW-1:0] digit_store [DIGIT_SLOTS];
    logic [CW-1:0] rd_data_reg;
    logic          wr_en;
    logic          rd_en;
    logic [CNTW-1:0] cnt_dec;

    // Divider connection.
    sirt_pkg::div_ctl_t div_ctl;
    sirt_pkg::div_sts_t div_sts;
    logic [NW-1:0]      magnitude;

    // Alphabet checking.
    logic [CW-1:0]  symbols [sirt_pkg::SYMBOL_COUNT];
    logic [CW-1:0]  chk_symbol;
    logic [LW-1:0]  chk_ext;
    logic           len_ok;
    logic           chk_bad;
    logic           accept;
    logic           slot_free;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_low_reg     <= '0;
            symbols_high_reg    <= '0;
            alphabet_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sirt_pkg::REG_SYMBOLS_LOW:     symbols_low_reg     <= cfg_data;
                sirt_pkg::REG_SYMBOLS_HIGH:    symbols_high_reg    <= cfg_data;
                sirt_pkg::REG_ALPHABET_LENGTH: alphabet_length_reg <= cfg_data[LW-1:0];
                default:                       ;
            endcase
        end
    end

    // Split the symbol registers into bytes.
    always_comb
    begin
        for (int k = 0; k < sirt_pkg::SYMBOL_COUNT; k++)
        begin
            if (k < 8)
            begin
                symbols[k] = symbols_low_reg[k*CW +: CW];
            end
            else
            begin
                symbols[k] = symbols_high_reg[(k-8)*CW +: CW];
            end
        end
    end

    // One symbol per cycle is checked against every later symbol in use.
    assign chk_ext    = LW'(chk_idx_reg);
    assign chk_symbol = symbols[SIW'(chk_idx_reg)];
    assign len_ok     = (alphabet_length_reg >= LW'(2)) &&
                        (alphabet_length_reg <= LW'(MAX_SYMBOLS));

    always_comb
    begin
        chk_bad = (chk_symbol == sirt_pkg::CH_MINUS) || (chk_symbol == sirt_pkg::CH_PLUS);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((LW'(j) > chk_ext) && (LW'(j) < alphabet_length_reg) &&
                (symbols[j] == chk_symbol))
            begin
                chk_bad = 1'b1;
            end
        end
    end

    // Two's complement magnitude; the most negative value maps to 2**31.
    assign magnitude = numbers.number[NW-1] ? (NW'(0) - NW'(numbers.number))
                                            : NW'(numbers.number);

    assign numbers.ready = (state_reg == sirt_pkg::ST_IDLE);
    assign accept        = numbers.valid && numbers.ready;
    assign slot_free     = !out_valid_reg || text.ready;
    assign cnt_dec       = CNTW'(cnt_reg - 1'b1);

    sirt_divider u_divider
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (div_ctl),
        .load_value (magnitude),
        .radix      (alphabet_length_reg),
        .sts        (div_sts)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        chk_idx_next   = chk_idx_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        div_ctl        = '0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            sirt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    div_ctl.load = 1'b1;
                    neg_next     = numbers.number[NW-1];
                    chk_idx_next = '0;
                    cnt_next     = '0;
                    state_next   = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK:
            begin
                priority if (!len_ok || chk_bad)
                begin
                    state_next = sirt_pkg::ST_IDLE;
                end
                else if (chk_ext == LW'(alphabet_length_reg - 1'b1))
                begin
                    state_next = neg_reg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_DIVIDE;
                end
                else
                begin
                    chk_idx_next = CHKW'(chk_idx_reg + 1'b1);
                end
            end
            sirt_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sirt_pkg::CH_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = sirt_pkg::ST_DIVIDE;
                end
            end
            sirt_pkg::ST_DIVIDE:
            begin
                div_ctl.step = 1'b1;
                if (div_sts.done)
                begin
                    wr_en    = 1'b1;
                    cnt_next = CNTW'(cnt_reg + 1'b1);
                    if (div_sts.quot_zero)
                    begin
                        state_next = sirt_pkg::ST_READ;
                    end
                end
            end
            sirt_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                cnt_next   = cnt_dec;
                state_next = sirt_pkg::ST_EMIT;
            end
            sirt_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data_reg;
                    out_last_next  = 1'b0;
                    state_next     = (cnt_reg == '0) ? sirt_pkg::ST_NEWLINE
                                                     : sirt_pkg::ST_READ;
                end
            end
            sirt_pkg::ST_NEWLINE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sirt_pkg::CH_NEWLINE;
                    out_last_next  = 1'b1;
                    state_next     = sirt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_store[cnt_reg[AW-1:0]] <= symbols[div_sts.rem];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= digit_store[cnt_dec[AW-1:0]];
        end
    end

    // Control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sirt_pkg::ST_IDLE;
            chk_idx_reg   <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_idx_reg   <= chk_idx_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last      = out_last_reg;

endmodule

// File: src/sirt_checker.sv
module sirt_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sirt_pkg::CHAR_W-1:0] out_character,
    input logic                        out_last
);

    // A character request that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("character request dropped while stalled");

    // A stalled character keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_character) && $stable(out_last))
    else $error("character payload changed while stalled");

    // A number is worked on before another is taken, so none follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second number taken right after the first");

    // The character that closes a text is always the newline.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_character == sirt_pkg::CH_NEWLINE)
    else $error("last flag on a character other than newline");

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (numbers.valid),
    .in_ready      (numbers.ready),
    .out_valid     (text.valid),
    .out_ready     (text.ready),
    .out_character (text.character),
    .out_last      (text.last)
);
